// ===== src/weighted_lottery_scheduler_defines.svh =====
// Assertion macros for the lottery scheduler.
`ifndef WEIGHTED_LOTTERY_SCHEDULER_DEFINES_SVH
`define WEIGHTED_LOTTERY_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define WLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");
`define WLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");
`else
`define WLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/wlsch_pkg.sv =====
package wlsch_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TASK_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int TIME_W = 20;
	localparam int BURST_W = 16;
	localparam int PRIO_W = 8;
	localparam int FRAC_W = 16;
	localparam int SUM_W = $clog2(MAX_TASKS * 510 + 1);
	localparam int PROD_W = SUM_W + FRAC_W;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [1:0] CFG_TASK_COUNT = 2'd0;
	localparam logic [1:0] CFG_TIME_SLICE = 2'd1;
	localparam logic [1:0] CFG_FAIR_BIAS = 2'd2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_DISPATCH = 1'b1;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef enum logic [1:0] {
		MODE_SCAN = 2'd0,
		MODE_SUM = 2'd1,
		MODE_PICK = 2'd2
	} mode_t;

	typedef struct packed {
		logic req_type;
		logic [3:0] entry_index;
		logic [19:0] arrival_in;
		logic [15:0] burst_in;
		logic [7:0] priority_in;
		logic [15:0] random_fraction;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] task_id;
		logic [19:0] slice_start;
		logic [19:0] slice_end;
		logic idle_jump;
		logic task_finished;
		logic [19:0] turnaround;
		logic [19:0] waiting;
	} res_t;

	// broadcast to every cell, steady during a pass
	typedef struct packed {
		mode_t mode;
		logic [TIME_W-1:0] now;
		logic [PROD_W-1:0] prod;
		logic [PRIO_W-1:0] bias;
		logic [CNT_W-1:0] cnt;
	} bcast_t;

	typedef struct packed {
		logic en;
		logic [TASK_W-1:0] index;
		logic [TIME_W-1:0] arr;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0] wt;
	} cell_wr_t;

	typedef struct packed {
		logic en;
		logic [TASK_W-1:0] index;
		logic [BURST_W-1:0] rem;
	} cell_upd_t;

	// token that travels the chain, one cell per cycle
	typedef struct packed {
		logic vld;
		logic any;
		logic pend;
		logic [TIME_W-1:0] earliest;
		logic [SUM_W-1:0] sum;
		logic picked;
		logic [TASK_W-1:0] chosen;
		logic [TIME_W-1:0] arr;
		logic [BURST_W-1:0] rem;
		logic [BURST_W-1:0] burst;
	} wave_t;

endpackage

// ===== src/weighted_lottery_scheduler.sv =====
// Weighted lottery scheduler.
// Input channel (in_valid/in_ready/in_data): one transaction is either a task
// write (loads one table entry) or a dispatch carrying a 16-bit random value.
// Output channel (out_valid/out_ready/out_data): exactly one result per input.
// cfg_en/cfg_index/cfg_data: single-cycle register writes; the user must make
// them only while idle, as the block does not enforce it. The task table lives
// in a row of MAX_TASKS cells; a token walks the row one cell per cycle. A
// dispatch makes three passes (find ready/earliest arrival, total weight,
// cumulative pick) plus a multiply and a finish state; its result is
// registered from the finish state, and the next transaction is taken once
// the block is back in idle. A dispatch with nothing to run stops after the
// first pass. A write goes straight to the finish state.
// One transaction is worked on at a time; in_ready is high only when idle.
// The result sits in an output register, so a new transaction is accepted
// while a result still waits. When a new result is done, the register is
// full and out_ready is low, the block holds in its finish state until it frees.
// Reset: current time zero, task_count 16, time_slice 2, fairness_bias 2.
// Table entries are undefined until written; no clearing pass is run.
`include "weighted_lottery_scheduler_defines.svh"
module weighted_lottery_scheduler (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input wlsch_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output wlsch_pkg::res_t out_data,
	input logic cfg_en,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_SUM = 6'b000100,
		ST_MULT = 6'b001000,
		ST_PICK = 6'b010000,
		ST_FIN = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_NONE = 2'd1,
		KIND_OK = 2'd2
	} kind_t;

	state_t state_q;
	kind_t kind_q;
	wlsch_pkg::req_t req_q;
	logic [4:0] task_count_q;
	logic [15:0] time_slice_q;
	logic [7:0] bias_q;
	logic [wlsch_pkg::TIME_W-1:0] time_q;
	logic jump_q;
	logic launch_q;
	logic [wlsch_pkg::SUM_W-1:0] total_q;
	logic [wlsch_pkg::PROD_W-1:0] prod_q;
	wlsch_pkg::mode_t mode_q;
	wlsch_pkg::wave_t pick_q;
	logic ov_q;
	wlsch_pkg::res_t res_q;

	logic [wlsch_pkg::CNT_W-1:0] cnt_eff;
	wlsch_pkg::bcast_t bc;
	wlsch_pkg::cell_wr_t wr;
	wlsch_pkg::cell_upd_t upd;
	wlsch_pkg::wave_t wave_in;
	wlsch_pkg::wave_t chain [wlsch_pkg::MAX_TASKS];
	wlsch_pkg::wave_t chain_out;
	logic out_free;
	logic fin_go;
	logic wr_ok;
	logic launch_go;

	// finish arithmetic
	logic [15:0] slice;
	logic [15:0] run;
	logic [wlsch_pkg::TIME_W:0] end_sum;
	logic [wlsch_pkg::TIME_W-1:0] end_t;
	logic [wlsch_pkg::TIME_W-1:0] ta;
	logic fin_task;
	wlsch_pkg::res_t res_c;

	// count above the table size saturates
	assign cnt_eff = (task_count_q > wlsch_pkg::CNT_W'(wlsch_pkg::MAX_TASKS))
		? wlsch_pkg::CNT_W'(wlsch_pkg::MAX_TASKS) : wlsch_pkg::CNT_W'(task_count_q);

	assign in_ready = state_q == ST_IDLE;
	assign out_free = !ov_q || out_ready;
	assign fin_go = state_q == ST_FIN && out_free;
	assign wr_ok = {1'b0, req_q.entry_index} < cnt_eff;

	// a token enters the row at the start of every pass
	assign launch_go = (state_q == ST_IDLE && in_valid
			&& in_data.req_type == wlsch_pkg::REQ_DISPATCH)
		|| (state_q == ST_SCAN && chain_out.vld && (chain_out.any || chain_out.pend))
		|| state_q == ST_MULT;

	always_comb begin
		bc.mode = mode_q;
		bc.now = time_q;
		bc.prod = prod_q;
		bc.bias = bias_q;
		bc.cnt = cnt_eff;
		wr.en = fin_go && kind_q == KIND_WRITE && wr_ok;
		wr.index = req_q.entry_index;
		wr.arr = req_q.arrival_in;
		wr.burst = req_q.burst_in;
		wr.wt = req_q.priority_in;
		wave_in = '0;
		wave_in.vld = launch_q;
	end

	for (genvar g = 0; g < wlsch_pkg::MAX_TASKS; g++) begin : g_cell
		if (g == 0) begin : g_head
			wlsch_cell u_cell (
				.clk(clk), .arst_n(arst_n), .idx(wlsch_pkg::TASK_W'(g)),
				.bc(bc), .wr(wr), .upd(upd),
				.wave_in(wave_in), .wave_out(chain[g])
			);
		end else begin : g_body
			wlsch_cell u_cell (
				.clk(clk), .arst_n(arst_n), .idx(wlsch_pkg::TASK_W'(g)),
				.bc(bc), .wr(wr), .upd(upd),
				.wave_in(chain[g-1]), .wave_out(chain[g])
			);
		end
	end

	assign chain_out = chain[wlsch_pkg::MAX_TASKS-1];

	// slice length, end time with saturation, completion stats
	always_comb begin
		slice = (time_slice_q == '0) ? 16'd1 : time_slice_q;
		run = (pick_q.rem < slice) ? pick_q.rem : slice;
		end_sum = {1'b0, time_q} + (wlsch_pkg::TIME_W + 1)'(run);
		end_t = end_sum[wlsch_pkg::TIME_W] ? wlsch_pkg::TIME_MAX
			: end_sum[wlsch_pkg::TIME_W-1:0];
		fin_task = pick_q.rem == run;
		ta = end_t - pick_q.arr;
		res_c = '0;
		case (kind_q)
			KIND_WRITE: res_c.status = wr_ok ? wlsch_pkg::STAT_OK : wlsch_pkg::STAT_RANGE;
			KIND_NONE: res_c.status = wlsch_pkg::STAT_NONE;
			KIND_OK: begin
				res_c.status = wlsch_pkg::STAT_OK;
				res_c.task_id = pick_q.chosen;
				res_c.slice_start = time_q;
				res_c.slice_end = end_t;
				res_c.idle_jump = jump_q;
				res_c.task_finished = fin_task;
				if (fin_task) begin
					res_c.turnaround = ta;
					res_c.waiting = (ta > wlsch_pkg::TIME_W'(pick_q.burst))
						? ta - wlsch_pkg::TIME_W'(pick_q.burst) : '0;
				end
			end
			default: ;
		endcase
		upd.en = fin_go && kind_q == KIND_OK;
		upd.index = pick_q.chosen;
		upd.rem = pick_q.rem - run;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= 5'd16;
			time_slice_q <= 16'd2;
			bias_q <= 8'd2;
		end else if (cfg_en) begin
			case (cfg_index)
				wlsch_pkg::CFG_TASK_COUNT: task_count_q <= cfg_data[4:0];
				wlsch_pkg::CFG_TIME_SLICE: time_slice_q <= cfg_data;
				wlsch_pkg::CFG_FAIR_BIAS: bias_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_q <= in_data;
		if (state_q == ST_SUM && chain_out.vld)
			total_q <= chain_out.sum;
		if (state_q == ST_MULT)
			prod_q <= wlsch_pkg::PROD_W'(req_q.random_fraction)
				* wlsch_pkg::PROD_W'(total_q);
		if (state_q == ST_PICK && chain_out.vld)
			pick_q <= chain_out;
		if (fin_go)
			res_q <= res_c;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_WRITE;
			mode_q <= wlsch_pkg::MODE_SCAN;
			time_q <= '0;
			jump_q <= 1'b0;
			launch_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			launch_q <= launch_go;
			// output register: loaded from finish, freed when taken
			ov_q <= fin_go || (ov_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						jump_q <= 1'b0;
						if (in_data.req_type == wlsch_pkg::REQ_WRITE) begin
							kind_q <= KIND_WRITE;
							state_q <= ST_FIN;
						end else begin
							mode_q <= wlsch_pkg::MODE_SCAN;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (chain_out.vld) begin
						if (!chain_out.any && !chain_out.pend) begin
							kind_q <= KIND_NONE;
							state_q <= ST_FIN;
						end else begin
							if (!chain_out.any) begin
								time_q <= chain_out.earliest;
								jump_q <= 1'b1;
							end
							mode_q <= wlsch_pkg::MODE_SUM;
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (chain_out.vld)
						state_q <= ST_MULT;
				end
				ST_MULT: begin
					mode_q <= wlsch_pkg::MODE_PICK;
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (chain_out.vld) begin
						kind_q <= KIND_OK;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (kind_q == KIND_OK)
							time_q <= end_t;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_data = res_q;

	// one transaction in flight at a time
	`WLS_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	// the token only leaves the chain during a pass
	`WLS_ASSERT_IMP(a_token_in_pass, clk, arst_n, chain_out.vld,
		state_q == ST_SCAN || state_q == ST_SUM || state_q == ST_PICK)
	// a new result is only loaded from the finish state
	`WLS_ASSERT_IMP(a_result_from_fin, clk, arst_n, $rose(out_valid),
		$past(state_q == ST_FIN))

endmodule

// ===== src/wlsch_cell.sv =====
module wlsch_cell (
	input logic clk,
	input logic arst_n,
	input logic [wlsch_pkg::TASK_W-1:0] idx,
	input wlsch_pkg::bcast_t bc,
	input wlsch_pkg::cell_wr_t wr,
	input wlsch_pkg::cell_upd_t upd,
	input wlsch_pkg::wave_t wave_in,
	output wlsch_pkg::wave_t wave_out
);

	logic [wlsch_pkg::TIME_W-1:0] arr_q;
	logic [wlsch_pkg::BURST_W-1:0] rem_q;
	logic [wlsch_pkg::BURST_W-1:0] burst_q;
	logic [wlsch_pkg::PRIO_W-1:0] wt_q;
	wlsch_pkg::wave_t wave_q;
	wlsch_pkg::wave_t w;
	logic act;
	logic rdy;
	logic pend_me;
	logic [wlsch_pkg::SUM_W-1:0] cum;

	// entry storage, undefined until written
	always_ff @(posedge clk) begin
		if (wr.en && wr.index == idx) begin
			arr_q <= wr.arr;
			rem_q <= wr.burst;
			burst_q <= wr.burst;
			wt_q <= wr.wt;
		end else if (upd.en && upd.index == idx) begin
			rem_q <= upd.rem;
		end
	end

	assign act = {1'b0, idx} < bc.cnt;
	assign rdy = act && rem_q != '0 && arr_q <= bc.now;
	assign pend_me = act && rem_q != '0 && arr_q > bc.now;
	assign cum = wave_in.sum + wlsch_pkg::SUM_W'(wt_q) + wlsch_pkg::SUM_W'(bc.bias);

	always_comb begin
		w = wave_in;
		if (wave_in.vld) begin
			case (bc.mode)
				wlsch_pkg::MODE_SCAN: begin
					if (rdy)
						w.any = 1'b1;
					if (pend_me && (!wave_in.pend || arr_q < wave_in.earliest)) begin
						w.pend = 1'b1;
						w.earliest = arr_q;
					end
				end
				wlsch_pkg::MODE_SUM: begin
					if (rdy)
						w.sum = cum;
				end
				wlsch_pkg::MODE_PICK: begin
					// later ready cells overwrite until a pick: last ready is the fallback
					if (rdy && !wave_in.picked) begin
						w.sum = cum;
						w.chosen = idx;
						w.arr = arr_q;
						w.rem = rem_q;
						w.burst = burst_q;
						w.picked = bc.prod < {cum, {wlsch_pkg::FRAC_W{1'b0}}};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= w;
		end
	end

	assign wave_out = wave_q;

endmodule

// ===== test/tb_weighted_lottery_scheduler.sv =====
`timescale 1ns / 1ps

module tb_weighted_lottery_scheduler;

	localparam int QUIET_LIMIT = 5000;   // cycles with no transaction before giving up
	localparam int SETTLE = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	wlsch_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wlsch_pkg::res_t out_data;
	logic cfg_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	weighted_lottery_scheduler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// scheduler shadow: table, clock and registers
	int unsigned sh_arr [wlsch_pkg::MAX_TASKS];
	int unsigned sh_rem [wlsch_pkg::MAX_TASKS];
	int unsigned sh_burst [wlsch_pkg::MAX_TASKS];
	int unsigned sh_prio [wlsch_pkg::MAX_TASKS];
	int unsigned sh_now = 0;
	int unsigned sh_count = 16;
	int unsigned sh_slice = 2;
	int unsigned sh_bias = 2;

	wlsch_pkg::req_t pending_q[$];      // transactions waiting to be offered
	wlsch_pkg::res_t slice_q[$];        // expected results, oldest first
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit in_taken = 1'b0;
	int fails = 0;
	int quiet = 0;
	int hold_left = 0;

	// next slice decision for one transaction, updates the shadow table
	function automatic wlsch_pkg::res_t predict_slice(wlsch_pkg::req_t q);
		wlsch_pkg::res_t o;
		int unsigned cnt, earliest, last, chosen, slice, run, fin, ta, idx;
		longint unsigned total, cum;
		bit any, pend, picked;
		o = '0;
		cnt = (sh_count > wlsch_pkg::MAX_TASKS) ? wlsch_pkg::MAX_TASKS : sh_count;
		if (q.req_type == wlsch_pkg::REQ_WRITE) begin
			idx = 32'(q.entry_index);
			if (idx >= cnt) begin
				o.status = wlsch_pkg::STAT_RANGE;
			end else begin
				sh_arr[idx] = 32'(q.arrival_in);
				sh_rem[idx] = 32'(q.burst_in);
				sh_burst[idx] = 32'(q.burst_in);
				sh_prio[idx] = 32'(q.priority_in);
			end
			return o;
		end
		any = 0;
		for (int i = 0; i < cnt; i++)
			if (sh_rem[i] != 0 && sh_arr[i] <= sh_now) any = 1;
		if (!any) begin
			pend = 0;
			earliest = 32'(wlsch_pkg::TIME_MAX);
			for (int i = 0; i < cnt; i++)
				if (sh_rem[i] != 0 && sh_arr[i] > sh_now && (!pend || sh_arr[i] < earliest)) begin
					earliest = sh_arr[i];
					pend = 1;
				end
			if (!pend) begin
				o.status = wlsch_pkg::STAT_NONE;
				return o;
			end
			sh_now = earliest;
			o.idle_jump = 1'b1;
		end
		total = 0;
		last = 0;
		for (int i = 0; i < cnt; i++)
			if (sh_rem[i] != 0 && sh_arr[i] <= sh_now) begin
				total += 64'(sh_prio[i]) + 64'(sh_bias);
				last = i;
			end
		// exact compare r/65536 < cum/total; zero total falls back to last ready
		cum = 0;
		picked = 0;
		chosen = last;
		for (int i = 0; i < cnt; i++)
			if (!picked && sh_rem[i] != 0 && sh_arr[i] <= sh_now) begin
				cum += 64'(sh_prio[i]) + 64'(sh_bias);
				if (64'(q.random_fraction) * total < cum * 64'd65536) begin
					chosen = i;
					picked = 1;
				end
			end
		slice = (sh_slice == 0) ? 1 : sh_slice;
		run = (sh_rem[chosen] < slice) ? sh_rem[chosen] : slice;
		fin = sh_now + run;
		if (fin > 32'(wlsch_pkg::TIME_MAX)) fin = 32'(wlsch_pkg::TIME_MAX);
		sh_rem[chosen] -= run;
		o.status = wlsch_pkg::STAT_OK;
		o.task_id = 4'(chosen);
		o.slice_start = 20'(sh_now);
		o.slice_end = 20'(fin);
		if (sh_rem[chosen] == 0) begin
			ta = fin - sh_arr[chosen];
			o.task_finished = 1'b1;
			o.turnaround = 20'(ta);
			o.waiting = (ta > sh_burst[chosen]) ? 20'(ta - sh_burst[chosen]) : 20'd0;
		end
		sh_now = fin;
		return o;
	endfunction

	// driver: offers the next queued transaction, random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// input acceptance feeds the predictor; output acceptance is checked
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			slice_q.insert(slice_q.size(), predict_slice(in_data));
		if (out_valid && out_ready) begin
			if (slice_q.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected result %p", out_data);
			end else if (out_data !== slice_q[0]) begin
				fails++;
				if (fails <= 10) $display("mismatch: expected %p got %p", slice_q[0], out_data);
				void'(slice_q.pop_front());
			end else begin
				void'(slice_q.pop_front());
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("weighted_lottery_scheduler regression: fail");
			$finish;
		end
	end

	function automatic void queue_item(wlsch_pkg::req_t q);
		pending_q.insert(pending_q.size(), q);
	endfunction

	function automatic wlsch_pkg::req_t write_item(int idx, int arr, int burst, int prio);
		wlsch_pkg::req_t q;
		q = '0;
		q.req_type = wlsch_pkg::REQ_WRITE;
		q.entry_index = 4'(idx);
		q.arrival_in = 20'(arr);
		q.burst_in = 16'(burst);
		q.priority_in = 8'(prio);
		return q;
	endfunction

	function automatic wlsch_pkg::req_t dispatch_item(int r);
		wlsch_pkg::req_t q;
		q = '0;
		q.req_type = wlsch_pkg::REQ_DISPATCH;
		q.random_fraction = 16'(r);
		return q;
	endfunction

	function automatic int sh_now_hint();
		return $urandom_range(3000);
	endfunction

	// mostly short bursts near the present, now and then full-range values
	function automatic wlsch_pkg::req_t random_item();
		wlsch_pkg::req_t q;
		if ($urandom_range(99) < 35) begin
			q = write_item($urandom_range(15),
				($urandom_range(9) == 0) ? $urandom_range(20'hFFFFF) : sh_now_hint(),
				($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(12),
				$urandom_range(255));
			q.random_fraction = 16'($urandom);
		end else begin
			q = dispatch_item($urandom_range(16'hFFFF));
			q.entry_index = 4'($urandom);
			q.arrival_in = 20'($urandom);
			q.burst_in = 16'($urandom);
			q.priority_in = 8'($urandom);
		end
		return q;
	endfunction

	task automatic drain();
		wait (pending_q.size() == 0 && !in_valid && slice_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, int value);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		if (idx == wlsch_pkg::CFG_TASK_COUNT) sh_count = value & 5'h1F;
		else if (idx == wlsch_pkg::CFG_TIME_SLICE) sh_slice = value & 16'hFFFF;
		else sh_bias = value & 8'hFF;
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	task automatic run_random(int n, int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 55; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 55; end
			default: begin send_idle_pct = 14; recv_stall_pct = 14; end
		endcase
		for (int i = 0; i < n; i++) queue_item(random_item());
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every entry gets written before the first dispatch, extremes on the ends
		queue_item(write_item(0, 0, 16'hFFFF, 255));
		for (int i = 1; i < 15; i++)
			queue_item(write_item(i, $urandom_range(40), $urandom_range(1, 6),
				$urandom_range(255)));
		queue_item(write_item(15, 20'hFFFFF, 1, 0));
		queue_item(dispatch_item(0));
		queue_item(dispatch_item(16'hFFFF));
		queue_item(dispatch_item(16'h8000));
		drain();

		// long receiver hold-off so the block backs up its input
		hold_req = 1'b1;
		run_random(110, 0);

		// all weights zero: fallback to the last ready entry
		set_reg(wlsch_pkg::CFG_FAIR_BIAS, 0);
		for (int i = 0; i < 16; i++) queue_item(write_item(i, 0, 3, 0));
		queue_item(dispatch_item(0));
		queue_item(dispatch_item(16'hFFFF));
		drain();
		// nothing left to run
		for (int i = 0; i < 16; i++) queue_item(write_item(i, 0, 0, 7));
		queue_item(dispatch_item(123));
		drain();

		set_reg(wlsch_pkg::CFG_TASK_COUNT, 5);
		set_reg(wlsch_pkg::CFG_TIME_SLICE, 1);
		run_random(110, 1);

		set_reg(wlsch_pkg::CFG_TASK_COUNT, 16);
		set_reg(wlsch_pkg::CFG_TIME_SLICE, 16'hFFFF);
		set_reg(wlsch_pkg::CFG_FAIR_BIAS, 255);
		run_random(110, 2);

		set_reg(wlsch_pkg::CFG_TASK_COUNT, 1);
		set_reg(wlsch_pkg::CFG_TIME_SLICE, 3);
		set_reg(wlsch_pkg::CFG_FAIR_BIAS, 7);
		run_random(110, 3);

		set_reg(wlsch_pkg::CFG_TASK_COUNT, $urandom_range(2, 15));
		set_reg(wlsch_pkg::CFG_TIME_SLICE, $urandom_range(1, 40));
		set_reg(wlsch_pkg::CFG_FAIR_BIAS, $urandom_range(255));
		run_random(110, 1);

		set_reg(wlsch_pkg::CFG_TASK_COUNT, 16);
		set_reg(wlsch_pkg::CFG_TIME_SLICE, 2);
		set_reg(wlsch_pkg::CFG_FAIR_BIAS, 2);
		run_random(110, 3);

		if (fails == 0) begin
			$display("weighted_lottery_scheduler regression: pass");
		end else begin
			$display("weighted_lottery_scheduler regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/wlsch_pkg.sv
src/wlsch_cell.sv
src/weighted_lottery_scheduler.sv
test/tb_weighted_lottery_scheduler.sv
